// ===== rtl/cbez_pkg.sv =====
// Shared constants for the cubic Bezier point evaluator.
package cbez_pkg;

  // Default coordinate width of a control point, whole pixels, signed
  localparam int COORD_BITS_DEF = 14;
  // Default number of fraction bits of the curve parameter t
  localparam int PARAM_FRAC_BITS_DEF = 16;
  // Fraction bits of a returned point (sixteenths of a pixel)
  localparam int POINT_FRAC_BITS = 4;
  // Width of the segment count register and of the sample index
  localparam int STEP_BITS = 10;
  // Segment count after reset
  localparam logic [STEP_BITS-1:0] STEP_RESET = 10'd100;

endpackage

// ===== rtl/cbez_sample_if.sv =====
// Valid/ready channels for curve samples in and curve points out.
interface cbez_sample_if
  import cbez_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] ctrl_one_x;
  logic signed [COORD_BITS-1:0] ctrl_one_y;
  logic signed [COORD_BITS-1:0] ctrl_two_x;
  logic signed [COORD_BITS-1:0] ctrl_two_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic        [STEP_BITS-1:0]  step_index;

  modport source (
    output valid, start_x, start_y, ctrl_one_x, ctrl_one_y,
           ctrl_two_x, ctrl_two_y, end_x, end_y, step_index,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, ctrl_one_x, ctrl_one_y,
           ctrl_two_x, ctrl_two_y, end_x, end_y, step_index,
    output ready
  );
endinterface

interface cbez_point_if
  import cbez_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                                         valid;
  logic                                         ready;
  logic signed [COORD_BITS+POINT_FRAC_BITS-1:0] point_x;
  logic signed [COORD_BITS+POINT_FRAC_BITS-1:0] point_y;
  logic                                         is_final_point;

  modport source (
    output valid, point_x, point_y, is_final_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, is_final_point,
    output ready
  );
endinterface

// ===== rtl/cubic_bezier_point_evaluator.sv =====
// Pipelined cubic Bezier evaluator: one curve point per sample item.
//
// Takes one sample item per clock while the output buffer is not full and
// returns one point per item, in order. Each item first forms
// t = floor(i * 2^PARAM_FRAC_BITS / step_count) in a divider pipeline that
// settles one quotient bit per stage, then evaluates the Bernstein form
// exactly as u^2*(u*P0 + 3t*P1) + t^2*(3u*P2 + t*P3), with the wide products
// split into two partial products each. An item passes the input register,
// divider, t and u, sums and squares, and partial product stages into a
// two-entry output buffer. Throughput is one item per cycle while it is not
// full: the pipeline keeps taking items while one point waits at the output
// and halts only when both entries are full. The index saturates to
// step_count, a step_count of zero acts as one, and the user must write
// step_count only while no item is in flight; the block does not enforce it.
module cubic_bezier_point_evaluator
  import cbez_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [STEP_BITS-1:0] cfg_write_data,
  cbez_sample_if.sink          samples,
  cbez_point_if.source         points
);

  localparam int CB    = COORD_BITS;
  localparam int F     = PARAM_FRAC_BITS;
  localparam int SB    = STEP_BITS;
  localparam int PB    = CB + POINT_FRAC_BITS;
  localparam int TW    = F + 1;             // t and u, up to 2^F
  localparam int T3W   = F + 2;             // 3t and 3u
  localparam int AW    = F + CB + 2;        // u*P0 + 3t*P1, signed
  localparam int UW    = 2 * F + 1;         // u^2 and t^2
  localparam int UL    = UW / 2;            // low part of a square
  localparam int UH    = UW - UL;           // high part of a square
  localparam int PHW   = UH + 1 + AW;       // high partial product
  localparam int PLW   = UL + 1 + AW;       // low partial product
  localparam int SW    = 3 * F + CB + 4;    // full Bernstein sum
  localparam int SHIFT = 3 * F - POINT_FRAC_BITS;
  localparam int NST   = F + 4;             // pipeline register stages
  localparam int ST_T  = F + 1;             // t, u stage
  localparam int ST_A  = F + 2;             // inner sums, squares
  localparam int ST_P  = F + 3;             // partial products
  localparam logic [TW-1:0] ONE = TW'(1) << F;
  localparam logic [1:0] BUF_FULL = 2'd2;

  // Segment count register, zero stored as one
  logic [SB-1:0] step_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_RESET;
    end else if (cfg_write_en) begin
      step_count <= (cfg_write_data == '0) ? SB'(1) : cfg_write_data;
    end
  end

  // Pipeline control: one enable for all stages, valid bits per stage
  logic [1:0]     buf_cnt;
  logic           adv;
  logic [NST-1:0] v;

  assign adv           = (buf_cnt != BUF_FULL);
  assign samples.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], samples.valid};
    end
  end

  // Payload registers
  logic [SB-1:0]         rem_q [F+1];
  logic [TW-1:0]         quo_q [F+1];
  logic signed [CB-1:0]  pts_q [F+2][8];
  logic [NST-1:0]        fin_q;
  logic [TW-1:0]         t_q, u_q;
  logic [T3W-1:0]        t3_q, u3_q;
  logic signed [AW-1:0]  a_q [2];
  logic signed [AW-1:0]  c_q [2];
  logic [UW-1:0]         uu_q, tt_q;
  logic signed [PHW-1:0] ph_a [2];
  logic signed [PLW-1:0] pl_a [2];
  logic signed [PHW-1:0] ph_c [2];
  logic signed [PLW-1:0] pl_c [2];

  // Saturate the index and set the integer bit of t
  logic [SB-1:0] idx_sat;
  logic          idx_final;

  assign idx_sat   = (samples.step_index > step_count) ? step_count : samples.step_index;
  assign idx_final = (idx_sat == step_count);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_q[0]    <= idx_final ? '0 : idx_sat;
      quo_q[0]    <= idx_final ? ONE : '0;
      fin_q[0]    <= idx_final;
      pts_q[0][0] <= samples.start_x;
      pts_q[0][1] <= samples.start_y;
      pts_q[0][2] <= samples.ctrl_one_x;
      pts_q[0][3] <= samples.ctrl_one_y;
      pts_q[0][4] <= samples.ctrl_two_x;
      pts_q[0][5] <= samples.ctrl_two_y;
      pts_q[0][6] <= samples.end_x;
      pts_q[0][7] <= samples.end_y;
    end
  end

  // Divide: one fraction bit of t per stage, restoring compare and subtract
  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [SB:0]   dbl;
    logic          ge;
    logic [SB:0]   diff;
    logic [TW-1:0] qn;

    assign dbl  = {rem_q[k-1], 1'b0};
    assign ge   = (dbl >= {1'b0, step_count});
    assign diff = dbl - {1'b0, step_count};
    assign qn   = quo_q[k-1] | ({{F{1'b0}}, ge} << (F - k));

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k] <= ge ? diff[SB-1:0] : dbl[SB-1:0];
        quo_q[k] <= qn;
        fin_q[k] <= fin_q[k-1];
        pts_q[k] <= pts_q[k-1];
      end
    end
  end

  // Form t, u and their triples
  logic [TW-1:0] u_next;

  assign u_next = ONE - quo_q[F];

  always_ff @(posedge clk) begin
    if (adv) begin
      t_q         <= quo_q[F];
      u_q         <= u_next;
      t3_q        <= T3W'(quo_q[F]) + (T3W'(quo_q[F]) << 1);
      u3_q        <= T3W'(u_next) + (T3W'(u_next) << 1);
      fin_q[ST_T] <= fin_q[F];
      pts_q[ST_T] <= pts_q[F];
    end
  end

  // Inner weighted sums per axis and the two squares
  always_ff @(posedge clk) begin
    if (adv) begin
      uu_q        <= UW'(u_q) * UW'(u_q);
      tt_q        <= UW'(t_q) * UW'(t_q);
      fin_q[ST_A] <= fin_q[ST_T];
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [SW-1:0] sum;

    always_ff @(posedge clk) begin
      if (adv) begin
        a_q[ax] <= $signed({1'b0, u_q}) * pts_q[ST_T][ax]
                 + $signed({1'b0, t3_q}) * pts_q[ST_T][2+ax];
        c_q[ax] <= $signed({1'b0, u3_q}) * pts_q[ST_T][4+ax]
                 + $signed({1'b0, t_q}) * pts_q[ST_T][6+ax];
      end
    end

    // Split each square into high and low parts for the outer products
    always_ff @(posedge clk) begin
      if (adv) begin
        ph_a[ax] <= $signed({1'b0, uu_q[UW-1:UL]}) * a_q[ax];
        pl_a[ax] <= $signed({1'b0, uu_q[UL-1:0]}) * a_q[ax];
        ph_c[ax] <= $signed({1'b0, tt_q[UW-1:UL]}) * c_q[ax];
        pl_c[ax] <= $signed({1'b0, tt_q[UL-1:0]}) * c_q[ax];
      end
    end

    // Recombine; the bit select is the floor shift to sixteenths
    assign sum = (SW'(ph_a[ax]) <<< UL) + SW'(pl_a[ax])
               + (SW'(ph_c[ax]) <<< UL) + SW'(pl_c[ax]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_q[ST_P] <= fin_q[ST_A];
    end
  end

  logic signed [PB-1:0] new_x, new_y;

  assign new_x = g_axis[0].sum[SHIFT+PB-1:SHIFT];
  assign new_y = g_axis[1].sum[SHIFT+PB-1:SHIFT];

  // Output buffer: two entries, head drives the port
  logic                 push, pop;
  logic signed [PB-1:0] head_x, head_y, tail_x, tail_y;
  logic                 head_fin, tail_fin;

  assign push = v[NST-1] && adv;
  assign pop  = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else begin
      case (buf_cnt)
        2'd0: begin
          if (push) buf_cnt <= 2'd1;
        end
        2'd1: begin
          if (push && !pop) buf_cnt <= BUF_FULL;
          else if (pop && !push) buf_cnt <= 2'd0;
        end
        BUF_FULL: begin
          if (pop) buf_cnt <= 2'd1;
        end
        default: begin
          buf_cnt <= '0;
        end
      endcase
    end
  end

  // Push to head if empty or drained, else to tail; pop from full moves tail up
  always_ff @(posedge clk) begin
    if (buf_cnt == BUF_FULL) begin
      if (pop) begin
        head_x   <= tail_x;
        head_y   <= tail_y;
        head_fin <= tail_fin;
      end
    end else if (push) begin
      if (buf_cnt == 2'd0 || pop) begin
        head_x   <= new_x;
        head_y   <= new_y;
        head_fin <= fin_q[ST_P];
      end else begin
        tail_x   <= new_x;
        tail_y   <= new_y;
        tail_fin <= fin_q[ST_P];
      end
    end
  end

  assign points.valid          = (buf_cnt != 2'd0);
  assign points.point_x        = head_x;
  assign points.point_y        = head_y;
  assign points.is_final_point = head_fin;

endmodule
